@@ hdl/vtfr_pkg.sv @@
// Shared types, constants and rate tables for the video timing frame rate block.
package vtfr_pkg;

	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 40;
	localparam int HTOT_W      = 18;
	localparam int VTOT_W      = 19;
	localparam int SFV_W       = 18;
	localparam int PCLK_W      = 32;
	localparam int AREA_W      = HTOT_W + VTOT_W;
	localparam int FRAC_W      = 16;
	localparam int P1000_W     = PCLK_W + 10;
	localparam int Q_W         = P1000_W + FRAC_W;
	localparam int CNT_W       = 6;
	localparam int M_W         = 24;
	localparam int DEN_W       = 10;
	localparam int IDX_W       = 4;
	localparam int MHZ_W       = 18;

	localparam int KNOWN_COUNT = 11;
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(KNOWN_COUNT - 1);
	localparam logic [9:0]       MHZ_PER_HZ = 10'd1000;
	localparam logic [MHZ_W-1:0] WINDOW_MHZ = 18'd120;
	localparam logic [M_W-1:0]   NUM_MAX    = 24'hFFFFFF;
	// inverse of 5 modulo 2^24; exact multiples of 5 map to at most the limit
	localparam logic [M_W-1:0]   INV5       = 24'hCCCCCD;
	localparam logic [M_W-1:0]   DIV5_LIMIT = 24'd3355443;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_MUL,
		ST_DIV,
		ST_MATCH,
		ST_ROUND,
		ST_TWO,
		ST_FIVE_MUL,
		ST_FIVE_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic total;
		logic mul;
		logic div_step;
		logic match_step;
		logic round;
		logic two;
		logic five_mul;
		logic five_chk;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic div_last;
		logic hit;
		logic match_last;
		logic five_more;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [MHZ_W-1:0] known_mhz(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd0:    known_mhz = 18'd23976;
			4'd1:    known_mhz = 18'd24000;
			4'd2:    known_mhz = 18'd25000;
			4'd3:    known_mhz = 18'd29970;
			4'd4:    known_mhz = 18'd30000;
			4'd5:    known_mhz = 18'd50000;
			4'd6:    known_mhz = 18'd59940;
			4'd7:    known_mhz = 18'd60000;
			4'd8:    known_mhz = 18'd100000;
			4'd9:    known_mhz = 18'd119880;
			default: known_mhz = 18'd120000;
		endcase
	endfunction

	function automatic logic [M_W-1:0] known_num(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd0:    known_num = 24'd24000;
			4'd1:    known_num = 24'd24;
			4'd2:    known_num = 24'd25;
			4'd3:    known_num = 24'd30000;
			4'd4:    known_num = 24'd30;
			4'd5:    known_num = 24'd50;
			4'd6:    known_num = 24'd60000;
			4'd7:    known_num = 24'd60;
			4'd8:    known_num = 24'd100;
			4'd9:    known_num = 24'd120000;
			default: known_num = 24'd120;
		endcase
	endfunction

	function automatic logic [DEN_W-1:0] known_den(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd0, 4'd3, 4'd6, 4'd9: known_den = 10'd1001;
			default:                known_den = 10'd1;
		endcase
	endfunction

	// 1000 / (2^a * 5^b)
	function automatic logic [DEN_W-1:0] den_of(input logic [1:0] a, input logic [1:0] b);
		logic [DEN_W-1:0] p5;
		case (b)
			2'd0:    p5 = 10'd125;
			2'd1:    p5 = 10'd25;
			2'd2:    p5 = 10'd5;
			default: p5 = 10'd1;
		endcase
		den_of = p5 << (2'd3 - a);
	endfunction

endpackage

@@ hdl/video_timing_frame_rate.sv @@
// Frame rate from measured video timings: top level.
// Takes one item at a time: a new input is accepted only after the result of the
// last one has been loaded into the output register, which waits while the output
// is stalled by m_axis_tready. The work per item is set by the 58-step restoring
// divider and the 11-entry rate scan. Reset clears control only.
module video_timing_frame_rate import vtfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// active_width, h_front_porch, h_sync_width, h_back_porch, active_height,
	// v_front_porch, v_sync_width, v_back_porch, second_field_vblank, pixel_clock_hz
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// is_interlaced
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// fps_numerator, fps_denominator
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status, known_rate_hit
	output logic [1:0]             m_axis_tuser
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	vtfr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	vtfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

@@ hdl/vtfr_ctrl.sv @@
// Sequencer for the frame rate computation.
module vtfr_ctrl import vtfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_axis_tvalid) state_d = ST_TOTAL;
			ST_TOTAL:    state_d = ST_MUL;
			ST_MUL:      state_d = stat.zero ? ST_DONE : ST_DIV;
			ST_DIV:      if (stat.div_last) state_d = ST_MATCH;
			ST_MATCH: begin
				if (stat.hit) state_d = ST_DONE;
				else if (stat.match_last) state_d = ST_ROUND;
			end
			ST_ROUND:    state_d = ST_TWO;
			ST_TWO:      state_d = ST_FIVE_MUL;
			ST_FIVE_MUL: state_d = ST_FIVE_CHK;
			ST_FIVE_CHK: state_d = stat.five_more ? ST_FIVE_MUL : ST_DONE;
			ST_DONE:     if (!stat.out_busy) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load = s_axis_tvalid;
			end
			ST_TOTAL:    cmd.total = 1'b1;
			ST_MUL:      cmd.mul = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_MATCH:    cmd.match_step = 1'b1;
			ST_ROUND:    cmd.round = 1'b1;
			ST_TWO:      cmd.two = 1'b1;
			ST_FIVE_MUL: cmd.five_mul = 1'b1;
			ST_FIVE_CHK: cmd.five_chk = 1'b1;
			ST_DONE:     cmd.out_load = !stat.out_busy;
			default:     cmd = '0;
		endcase
	end

endmodule

@@ hdl/vtfr_dp.sv @@
// Datapath: totals, area, restoring divider, rate match and fraction reduction.
module vtfr_dp import vtfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat
);

	logic [IN_TDATA_W-1:0]  in_q;
	logic                   ilace_q;
	logic [HTOT_W-1:0]      htot_q;
	logic [VTOT_W-1:0]      vtot_q;
	logic [PCLK_W-1:0]      pclk_q;
	logic [AREA_W-1:0]      area_q;
	logic [AREA_W-1:0]      rem_q;
	logic [Q_W-1:0]         dvd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   unavail_q;
	logic                   hit_q;
	logic [M_W-1:0]         m_q;
	logic [M_W-1:0]         t_q;
	logic [1:0]             a_q;
	logic [1:0]             b_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [1:0]             out_user_q;

	logic [AREA_W:0]        rem_shift;
	logic                   rem_ge;
	logic [MHZ_W-1:0]       k_mhz;
	logic [Q_W-1:0]         k_lo, k_hi;
	logic                   hit;
	logic [Q_W:0]           q_round;
	logic [Q_W-FRAC_W:0]    m_full;
	logic [1:0]             tz;
	logic [2*M_W-1:0]       prod5;
	logic                   five_ok;

	always_comb begin
		rem_shift = {rem_q, dvd_q[Q_W-1]};
		rem_ge    = rem_shift >= {1'b0, area_q};
		k_mhz     = known_mhz(idx_q);
		k_lo      = {(P1000_W - MHZ_W)'(0), k_mhz - WINDOW_MHZ, FRAC_W'(0)};
		k_hi      = {(P1000_W - MHZ_W)'(0), k_mhz + WINDOW_MHZ, FRAC_W'(0)};
		hit       = (dvd_q > k_lo) && (dvd_q < k_hi);
		q_round   = {1'b0, dvd_q} + (Q_W + 1)'(1 << (FRAC_W - 1));
		m_full    = q_round[Q_W:FRAC_W];
		if (m_q[0]) tz = 2'd0;
		else if (m_q[1]) tz = 2'd1;
		else if (m_q[2]) tz = 2'd2;
		else tz = 2'd3;
		prod5   = m_q * INV5;
		five_ok = t_q <= DIV5_LIMIT;
	end

	assign stat.zero       = (htot_q == '0) || (vtot_q == '0) || (pclk_q == '0);
	assign stat.div_last   = cnt_q == DIV_LAST;
	assign stat.hit        = hit;
	assign stat.match_last = idx_q == IDX_LAST;
	assign stat.five_more  = five_ok && (b_q != 2'd2);
	assign stat.out_busy   = out_valid_q && !m_axis_tready;

	// input capture and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q    <= s_axis_tdata;
			ilace_q <= s_axis_tuser;
		end
		if (cmd.total) begin
			htot_q <= HTOT_W'(in_q[15:0]) + HTOT_W'(in_q[31:16])
			        + HTOT_W'(in_q[47:32]) + HTOT_W'(in_q[63:48]);
			vtot_q <= VTOT_W'(in_q[79:64]) + VTOT_W'(in_q[95:80])
			        + VTOT_W'(in_q[111:96]) + VTOT_W'(in_q[127:112])
			        + (ilace_q ? VTOT_W'(in_q[145:128]) : VTOT_W'(0));
			pclk_q <= in_q[177:146];
		end
		if (cmd.mul) begin
			area_q    <= htot_q * vtot_q;
			dvd_q     <= {P1000_W'(pclk_q) * P1000_W'(MHZ_PER_HZ), FRAC_W'(0)};
			rem_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			unavail_q <= stat.zero;
			hit_q     <= 1'b0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? AREA_W'(rem_shift - {1'b0, area_q}) : rem_shift[AREA_W-1:0];
			dvd_q <= {dvd_q[Q_W-2:0], rem_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.match_step) begin
			if (hit) hit_q <= 1'b1;
			else idx_q <= idx_q + 1'b1;
		end
		if (cmd.round) begin
			if (m_full == '0) m_q <= M_W'(1);
			else if (m_full > (Q_W - FRAC_W + 1)'(NUM_MAX)) m_q <= NUM_MAX;
			else m_q <= m_full[M_W-1:0];
			b_q <= 2'd0;
		end
		if (cmd.two) begin
			a_q <= tz;
			m_q <= m_q >> tz;
		end
		if (cmd.five_mul) t_q <= prod5[M_W-1:0];
		if (cmd.five_chk && five_ok) begin
			m_q <= t_q;
			b_q <= b_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (unavail_q) begin
				out_data_q <= '0;
				out_user_q <= 2'b01;
			end else if (hit_q) begin
				out_data_q <= {6'd0, known_den(idx_q), known_num(idx_q)};
				out_user_q <= 2'b10;
			end else begin
				out_data_q <= {6'd0, den_of(a_q, b_q), m_q};
				out_user_q <= 2'b00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
